/* rtl/ppm_pkg.sv */
// Package: shared types and constants of the projective pixel mapper.
package ppm_pkg;

  localparam int NUM_COEF = 8;
  localparam int ADDR_W   = 5;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = 45;  // 32-bit coefficient times 13-bit signed coordinate
  localparam int SUM_W    = 47;  // sum of two products and an offset
  localparam int MAG_W    = 46;  // magnitude of a sum
  localparam int NQ       = 29;  // quotient bits kept, Q12.16 plus one guard bit
  localparam int HI_W     = MAG_W + 16 - NQ;  // dividend bits above the quotient window
  localparam logic signed [SUM_W-1:0] ONE_Q16 = 47'sd65536;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [2:0] {
    REG_XX   = 3'd0,
    REG_XY   = 3'd1,
    REG_XOFF = 3'd2,
    REG_YX   = 3'd3,
    REG_YY   = 3'd4,
    REG_YOFF = 3'd5,
    REG_WX   = 3'd6,
    REG_WY   = 3'd7
  } reg_idx_t;

  // One transaction as it travels down the divider chain.
  typedef struct packed {
    logic              valid;
    logic              okx;
    logic              oky;
    logic [MAG_W-1:0]  wmag;
    logic [MAG_W-1:0]  remx;
    logic [MAG_W-1:0]  remy;
    logic [NQ-1:0]     tx;   // remaining dividend bits in, quotient bits out
    logic [NQ-1:0]     ty;
    logic [23:0]       pixel;
  } cell_t;

endpackage

/* rtl/ppm_if.sv */
// Interfaces: input and output streaming channels of the pixel mapper.
interface ppm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_x;
  logic [11:0] src_y;
  logic [23:0] pixel_value;
  modport source (output valid, src_x, src_y, pixel_value, input ready);
  modport sink   (input valid, src_x, src_y, pixel_value, output ready);
endinterface

interface ppm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic        inside_res;
  logic [23:0] pixel_out;
  modport source (output valid, dest_x, dest_y, inside_res, pixel_out, input ready);
  modport sink   (input valid, dest_x, dest_y, inside_res, pixel_out, output ready);
endinterface

/* rtl/ppm_regs.sv */
// Coefficient register file behind the APB-style port.
module ppm_regs import ppm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output coef_t             coefs [NUM_COEF]
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign prdata = coefs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) coefs[i] <= '0;
      coefs[REG_XX] <= 32'sd65536;
      coefs[REG_YY] <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      coefs[idx] <= pwdata;
    end
  end

endmodule

/* rtl/ppm_front.sv */
// Front end: products, sums, and sign/magnitude split feeding the divider chain.
module ppm_front import ppm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  ppm_in_if.sink in_ch,
  input  coef_t coefs [NUM_COEF],
  input  logic  adv_in,
  output cell_t c_out
);

  logic v1, v2, adv1, adv2, adv3;
  logic signed [PROD_W-1:0] pxx, pxy, pyx, pyy, pwx, pwy;
  logic signed [SUM_W-1:0]  nx, ny, nw;
  logic [23:0] pix1, pix2;
  logic signed [12:0] xs, ys;
  logic [MAG_W-1:0] mx, my, mw;

  assign adv3 = ~c_out.valid | adv_in;
  assign adv2 = ~v2 | adv3;
  assign adv1 = ~v1 | adv2;
  assign in_ch.ready = adv1;

  assign xs = $signed({1'b0, in_ch.src_x});
  assign ys = $signed({1'b0, in_ch.src_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_ch.valid;
    end
    if (adv1) begin
      pxx  <= coefs[REG_XX] * xs;
      pxy  <= coefs[REG_XY] * ys;
      pyx  <= coefs[REG_YX] * xs;
      pyy  <= coefs[REG_YY] * ys;
      pwx  <= coefs[REG_WX] * xs;
      pwy  <= coefs[REG_WY] * ys;
      pix1 <= in_ch.pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      nx   <= SUM_W'(pxx) + SUM_W'(pxy) + SUM_W'(coefs[REG_XOFF]);
      ny   <= SUM_W'(pyx) + SUM_W'(pyy) + SUM_W'(coefs[REG_YOFF]);
      nw   <= SUM_W'(pwx) + SUM_W'(pwy) + ONE_Q16;
      pix2 <= pix1;
    end
  end

  // Magnitudes stay below 2^46, so the negation never overflows.
  assign mx = nx[SUM_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
  assign my = ny[SUM_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
  assign mw = nw[SUM_W-1] ? MAG_W'(-nw) : MAG_W'(nw);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (adv3) begin
      c_out.valid <= v2;
    end
    if (adv3) begin
      // Positive quotient needs equal signs; a high part at or above W overflows the window.
      c_out.okx   <= (nx[SUM_W-1] == nw[SUM_W-1]) && (MAG_W'(mx[MAG_W-1:MAG_W-HI_W]) < mw);
      c_out.oky   <= (ny[SUM_W-1] == nw[SUM_W-1]) && (MAG_W'(my[MAG_W-1:MAG_W-HI_W]) < mw);
      c_out.wmag  <= mw;
      c_out.remx  <= MAG_W'(mx[MAG_W-1:MAG_W-HI_W]);
      c_out.remy  <= MAG_W'(my[MAG_W-1:MAG_W-HI_W]);
      c_out.tx    <= {mx[MAG_W-HI_W-1:0], 16'b0};
      c_out.ty    <= {my[MAG_W-HI_W-1:0], 16'b0};
      c_out.pixel <= pix2;
    end
  end

endmodule

/* rtl/ppm_div_cell.sv */
// Divider cell: one restoring quotient bit for both axes.
module ppm_div_cell import ppm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t c_in,
  input  logic  adv_in,
  output logic  adv_out,
  output cell_t c_out
);

  logic [MAG_W:0] rx, ry, wz;
  logic gx, gy;

  assign adv_out = ~c_out.valid | adv_in;
  assign wz = {1'b0, c_in.wmag};
  assign rx = {c_in.remx, c_in.tx[NQ-1]};
  assign ry = {c_in.remy, c_in.ty[NQ-1]};
  assign gx = rx >= wz;
  assign gy = ry >= wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (adv_out) begin
      c_out.valid <= c_in.valid;
    end
    if (adv_out) begin
      c_out.okx   <= c_in.okx;
      c_out.oky   <= c_in.oky;
      c_out.wmag  <= c_in.wmag;
      c_out.remx  <= gx ? MAG_W'(rx - wz) : MAG_W'(rx);
      c_out.remy  <= gy ? MAG_W'(ry - wz) : MAG_W'(ry);
      c_out.tx    <= {c_in.tx[NQ-2:0], gx};
      c_out.ty    <= {c_in.ty[NQ-2:0], gy};
      c_out.pixel <= c_in.pixel;
    end
  end

endmodule

/* rtl/projective_pixel_map_top.sv */
// Top level: projective pixel mapper with APB coefficients and a divider cell chain.
//
// Usage: source pixels enter on in_ch (valid/ready), one transaction per
// clock at full rate. Each gives one transaction on out_ch: the destination
// column and row (integer part of X/W and Y/W), the inside flag and the
// pixel passed through. Points outside the image, or with W equal to zero,
// report inside_res low and zero coordinates.
// Pipeline: 3 front stages (products, sums, sign split), 29 divider cells
// (one quotient bit each for both axes) and the output register.
// Throughput: one transaction per cycle while out_ch does not stall, set by
// the chain of divider cells that each hand their partial remainder onward.
// Coefficients must be written through the APB port only while the stream
// is idle; the block itself does not enforce this. Reset clears all valid
// flags and loads the identity coefficients. When out_ch stalls, each stage
// holds only while it is full and the stage after it holds, so bubbles
// collapse and in_ch keeps accepting until the whole pipe is occupied.
module projective_pixel_map_top import ppm_pkg::*; #(
  parameter int IMG_WIDTH  = 640,
  parameter int IMG_HEIGHT = 480
) (
  input  logic              clk,
  input  logic              rst,
  ppm_in_if.sink            in_ch,
  ppm_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [NQ-1:0] LIM_X = NQ'(IMG_WIDTH * 65536);
  localparam logic [NQ-1:0] LIM_Y = NQ'(IMG_HEIGHT * 65536);

  coef_t coefs [NUM_COEF];
  cell_t chain [NQ+1];
  logic  adv   [NQ+1];
  logic  adv_out, in_x, in_y, in_img;

  ppm_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coefs
  );

  ppm_front u_front (
    .clk, .rst, .in_ch, .coefs, .adv_in(adv[0]), .c_out(chain[0])
  );

  for (genvar i = 0; i < NQ; i++) begin : g_cell
    ppm_div_cell u_cell (
      .clk, .rst, .c_in(chain[i]), .adv_in(adv[i+1]), .adv_out(adv[i]), .c_out(chain[i+1])
    );
  end

  // Final window check on the finished quotients.
  assign adv_out = ~out_ch.valid | out_ch.ready;
  assign adv[NQ] = adv_out;
  assign in_x    = chain[NQ].okx && (chain[NQ].tx != '0) && (chain[NQ].tx < LIM_X);
  assign in_y    = chain[NQ].oky && (chain[NQ].ty != '0) && (chain[NQ].ty < LIM_Y);
  assign in_img  = in_x && in_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv_out) begin
      out_ch.valid <= chain[NQ].valid;
    end
    if (adv_out) begin
      out_ch.inside_res <= in_img;
      out_ch.dest_x     <= in_img ? chain[NQ].tx[27:16] : 12'd0;
      out_ch.dest_y     <= in_img ? chain[NQ].ty[27:16] : 12'd0;
      out_ch.pixel_out  <= chain[NQ].pixel;
    end
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.inside_res |-> out_ch.dest_x == 12'd0 && out_ch.dest_y == 12'd0)
    else $error("outside point carries nonzero coordinates");

  a_last_cell_holds: assert property (@(posedge clk) disable iff (rst)
    chain[NQ].valid && !adv_out |=> chain[NQ].valid && $stable(chain[NQ].pixel))
    else $error("last divider cell dropped a stalled transaction");

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !chain[0].valid |-> in_ch.ready)
    else $error("input stalled with an empty front stage");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> coefs[$past(paddr[ADDR_W-1:2])] == $past(pwdata))
    else $error("coefficient write not stored");

endmodule

/* test/tb_top.sv */
// Testbench: projective pixel mapper, checked against a fixed-point predictor.
module tb_top;
  import ppm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_W      = 640;
  localparam int IMG_H      = 480;
  localparam int PIPE_DRAIN = 40;      // margin beyond the pipeline depth
  localparam int CYCLE_CAP  = 400000;  // far above the slowest correct run
  localparam int GAP_PCT    = 22;

  typedef struct {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic        inside_res;
    logic [23:0] pixel_out;
  } mapped_px_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppm_in_if  in_ch();
  ppm_out_if out_ch();

  projective_pixel_map_top #(.IMG_WIDTH(IMG_W), .IMG_HEIGHT(IMG_H)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the coefficient bank, identity after reset.
  coef_t      coef_bank [NUM_COEF];
  mapped_px_t mapped_q [$];
  int         errors = 0;
  int         cycles = 0;
  bit         send_steady = 1'b0;  // sender: no gaps while set
  bit         recv_steady = 1'b0;  // receiver: no stalls while set
  bit         hold_req = 1'b0;     // ask the receiver for one long hold-off
  int         hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.src_x = '0;
    in_ch.src_y = '0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the pipe fills up and in_ch backs off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= GAP_PCT);
    end
  end

  // One axis of the division: quotient with 16 fraction bits, truncated
  // toward zero, must land strictly between 0 and the image size.
  function automatic bit axis_fits(longint num, longint den, longint lim,
                                   output logic [11:0] coord);
    longint q;
    q = (num * 65536) / den;
    coord = '0;
    if (q > 0 && q < lim * 65536) begin
      coord = q[27:16];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mapped_px_t map_pixel(logic [11:0] sx, logic [11:0] sy,
                                           logic [23:0] pix);
    longint     x, y, nx, ny, w;
    logic [11:0] cx, cy;
    bit         okx, oky;
    mapped_px_t r;
    x  = longint'(sx);
    y  = longint'(sy);
    nx = longint'(coef_bank[REG_XX]) * x + longint'(coef_bank[REG_XY]) * y
         + longint'(coef_bank[REG_XOFF]);
    ny = longint'(coef_bank[REG_YX]) * x + longint'(coef_bank[REG_YY]) * y
         + longint'(coef_bank[REG_YOFF]);
    w  = longint'(coef_bank[REG_WX]) * x + longint'(coef_bank[REG_WY]) * y + 65536;
    r.dest_x = '0;
    r.dest_y = '0;
    r.inside_res = 1'b0;
    r.pixel_out = pix;
    // A zero denominator always counts as outside.
    if (w != 0) begin
      okx = axis_fits(nx, w, IMG_W, cx);
      oky = axis_fits(ny, w, IMG_H, cy);
      if (okx && oky) begin
        r.dest_x = cx;
        r.dest_y = cy;
        r.inside_res = 1'b1;
      end
    end
    return r;
  endfunction

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    mapped_px_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (mapped_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = mapped_q.pop_front();
        if (out_ch.dest_x !== e.dest_x) begin
          $error("dest_x: expected %0d, got %0d", e.dest_x, out_ch.dest_x);
          errors++;
        end
        if (out_ch.dest_y !== e.dest_y) begin
          $error("dest_y: expected %0d, got %0d", e.dest_y, out_ch.dest_y);
          errors++;
        end
        if (out_ch.inside_res !== e.inside_res) begin
          $error("inside_res: expected %0b, got %0b", e.inside_res, out_ch.inside_res);
          errors++;
        end
        if (out_ch.pixel_out !== e.pixel_out) begin
          $error("pixel_out: expected %h, got %h", e.pixel_out, out_ch.pixel_out);
          errors++;
        end
      end
    end
  end

  // Offer one pixel; drop valid only for a random gap, then hold until taken.
  task automatic send_pixel(logic [11:0] sx, logic [11:0] sy, logic [23:0] pix);
    while (!send_steady && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_x <= sx;
    in_ch.src_y <= sy;
    in_ch.pixel_value <= pix;
    do @(posedge clk); while (!in_ch.ready);
    mapped_q.push_back(map_pixel(sx, sy, pix));
    @(negedge clk);
  endtask

  // Let the stream run dry, then leave valid low.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (mapped_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready, then back to idle.
  task automatic write_coef(reg_idx_t idx, coef_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    coef_bank[idx] = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_matrix(coef_t xx, coef_t xy, coef_t xo, coef_t yx, coef_t yy,
                             coef_t yo, coef_t wx, coef_t wy);
    wait_idle();
    write_coef(REG_XX, xx);
    write_coef(REG_XY, xy);
    write_coef(REG_XOFF, xo);
    write_coef(REG_YX, yx);
    write_coef(REG_YY, yy);
    write_coef(REG_YOFF, yo);
    write_coef(REG_WX, wx);
    write_coef(REG_WY, wy);
  endtask

  function automatic logic [11:0] rnd12();
    return 12'($urandom);
  endfunction

  function automatic logic [23:0] rnd24();
    return 24'($urandom);
  endfunction

  function automatic coef_t rnd_signed(int span);
    return coef_t'($urandom_range(2 * span) - span);
  endfunction

  // Image corners, bounds, zero denominator, tiny quotients and coefficient extremes.
  task automatic test_directed();
    // identity from reset: origin truncates to zero, so it is outside
    send_pixel(12'd0, 12'd0, 24'h000000);
    send_pixel(12'd1, 12'd1, 24'hFFFFFF);
    send_pixel(12'd639, 12'd479, 24'hA5A5A5);
    send_pixel(12'd640, 12'd100, 24'h5A5A5A);
    send_pixel(12'd100, 12'd480, 24'h123456);
    send_pixel(12'd4095, 12'd4095, 24'hFFFFFF);
    send_pixel(12'd0, 12'd200, 24'h000001);
    // W = 1 - x, so column 1 divides by zero
    load_matrix(32'sd65536, 0, 32'sd65536 * 5, 0, 32'sd65536, 32'sd65536 * 5,
                -32'sd65536, 0);
    send_pixel(12'd1, 12'd10, 24'h800000);
    send_pixel(12'd0, 12'd10, 24'h7FFFFF);
    send_pixel(12'd2, 12'd10, 24'h010101);
    // huge W drives the quotient below one LSB
    load_matrix(32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 32'sh7FFF_FFFF);
    send_pixel(12'd1, 12'd4095, 24'hFEDCBA);
    send_pixel(12'd300, 12'd4095, 24'h00FF00);
    send_pixel(12'd2, 12'd0, 24'h0000FF);
    // coefficient extremes
    load_matrix(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_pixel(12'd4095, 12'd0, 24'hFFFFFF);
    send_pixel(12'd0, 12'd4095, 24'h000000);
    send_pixel(12'd4095, 12'd4095, 24'h555555);
    send_pixel(12'd0, 12'd0, 24'hAAAAAA);
  endtask

  // Identity matrix, full coordinate range, no gaps in the first half.
  task automatic test_identity();
    load_matrix(32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 0);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i == 75) begin
        send_steady = 1'b0;
        recv_steady = 1'b0;
      end
      send_pixel(rnd12(), rnd12(), rnd24());
    end
  endtask

  // Affine scaling into the image, with a long output hold-off early in each set.
  task automatic test_affine_pressure();
    for (int set = 0; set < 2; set++) begin
      load_matrix(coef_t'($urandom_range(19661, 3277)), rnd_signed(8000),
                  rnd_signed(6553600), rnd_signed(8000),
                  coef_t'($urandom_range(14000, 2500)), rnd_signed(6553600), 0, 0);
      for (int i = 0; i < 125; i++) begin
        if (i == 20) hold_req = 1'b1;
        send_pixel(rnd12(), rnd12(), rnd24());
      end
    end
  endtask

  // Mild perspective: W crosses zero and turns negative over the frame.
  task automatic test_projective();
    for (int set = 0; set < 4; set++) begin
      load_matrix(coef_t'($urandom_range(40000, 4000)), rnd_signed(6000),
                  rnd_signed(3276800), rnd_signed(6000),
                  coef_t'($urandom_range(40000, 4000)), rnd_signed(3276800),
                  rnd_signed(40), rnd_signed(40));
      for (int i = 0; i < 50; i++) begin
        send_pixel(rnd12(), rnd12(), rnd24());
      end
    end
  endtask

  // Fully random coefficient words.
  task automatic test_extreme();
    for (int set = 0; set < 4; set++) begin
      load_matrix(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                  coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                  coef_t'($urandom), coef_t'($urandom));
      for (int i = 0; i < 50; i++) begin
        send_pixel(rnd12(), rnd12(), rnd24());
      end
    end
  endtask

  initial begin
    coef_bank[REG_XX]   = 32'sd65536;
    coef_bank[REG_XY]   = 0;
    coef_bank[REG_XOFF] = 0;
    coef_bank[REG_YX]   = 0;
    coef_bank[REG_YY]   = 32'sd65536;
    coef_bank[REG_YOFF] = 0;
    coef_bank[REG_WX]   = 0;
    coef_bank[REG_WY]   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_directed();
    test_identity();
    test_affine_pressure();
    test_projective();
    test_extreme();
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ppm_pkg.sv
rtl/ppm_if.sv
rtl/ppm_regs.sv
rtl/ppm_front.sv
rtl/ppm_div_cell.sv
rtl/projective_pixel_map_top.sv
test/tb_top.sv
